// ===== hdl/swing_step_detector_core_assert.svh =====
`ifndef SWING_STEP_DETECTOR_CORE_ASSERT_SVH
`define SWING_STEP_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ssd_pkg.sv =====
`default_nettype none

package ssd_pkg;

    localparam int WINDOW_DEF = 10;

    localparam int PITCH_W    = 17;
    localparam int TIME_W     = 40;
    localparam int COUNT_W    = 32;
    localparam int MIN_INT_W  = 16;
    localparam int DEADBAND_W = 12;
    localparam int MOTION_W   = 2;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [MIN_INT_W-1:0]  MIN_INT_RST  = 16'd300;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 12'd26;

    localparam logic [MOTION_W-1:0] MOTION_UNKNOWN = 2'd0;
    localparam logic [MOTION_W-1:0] MOTION_RISING  = 2'd1;
    localparam logic [MOTION_W-1:0] MOTION_FALLING = 2'd2;

    localparam logic REG_MIN_INTERVAL = 1'b0;
    localparam logic REG_DEADBAND     = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/swing_step_detector_core.sv =====
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------------
// sample    | sample_valid / sample_ready  | pitch_sample, time_ms
// result    | result_valid / result_ready  | step_detected, step_count, smoothed_pitch,
//           |                              | motion
// config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A request passes through S_UPD, S_DIV, S_DEC and S_OUT from acceptance to result.
// S_DIV runs the radix-4 divider that forms sum / fill, two quotient bits a cycle.
// The sample window sits in a one-port synchronous ring: read on accept, written back next cycle.
// Reset (rst_n, async, low) empties the window by clearing the fill count; no memory sweep.
// A new request is taken while the previous result still waits on result_ready.
`default_nettype none

module swing_step_detector_core #(
    parameter int WINDOW = ssd_pkg::WINDOW_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire logic signed [ssd_pkg::PITCH_W-1:0]  pitch_sample,
    input  wire logic [ssd_pkg::TIME_W-1:0]          time_ms,

    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic                                     step_detected,
    output logic [ssd_pkg::COUNT_W-1:0]              step_count,
    output logic signed [ssd_pkg::PITCH_W-1:0]       smoothed_pitch,
    output logic [ssd_pkg::MOTION_W-1:0]             motion,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ssd_pkg::APB_AW-1:0]          paddr,
    input  wire logic [ssd_pkg::APB_DW-1:0]          pwdata,
    output logic [ssd_pkg::APB_DW-1:0]               prdata,
    output logic                                     pready
);

    import ssd_pkg::*;

    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W     = PITCH_W + CNT_W;
    localparam int DIV_STEPS = (SUM_W + 1) / 2;
    localparam int QW        = 2 * DIV_STEPS;
    localparam int DSC_W     = $clog2(DIV_STEPS + 1);
    localparam int CMP_W     = PITCH_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_DIV,
        S_DEC,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic [MIN_INT_W-1:0]      min_int_reg;
    logic [DEADBAND_W-1:0]     deadband_reg;

    logic [PITCH_W-1:0]        ring_mem [WINDOW];
    logic [PITCH_W-1:0]        ring_rd_reg;

    logic [POS_W-1:0]          pos_reg;
    logic [CNT_W-1:0]          fill_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [PITCH_W-1:0] prev_reg;
    logic [MOTION_W-1:0]       motion_reg;
    logic [TIME_W-1:0]         last_reg;
    logic [COUNT_W-1:0]        total_reg;

    logic [PITCH_W-1:0]        sample_reg;
    logic [TIME_W-1:0]         time_reg;
    logic                      gap_ok_reg;
    logic                      neg_reg;
    logic [QW-1:0]             dvd_reg;
    logic [CNT_W:0]            rem_reg;
    logic [CNT_W-1:0]          dsr_reg;
    logic [DSC_W-1:0]          dcnt_reg;
    logic                      step_reg;

    logic                      res_valid_reg;
    logic                      res_step_reg;
    logic [COUNT_W-1:0]        res_count_reg;
    logic [PITCH_W-1:0]        res_avg_reg;
    logic [MOTION_W-1:0]       res_motion_reg;

    logic                      accept;
    logic                      cfg_wr;
    logic                      full;
    logic                      ring_wr;
    logic [POS_W-1:0]          pos_next;
    logic [CNT_W-1:0]          fill_next;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]          mag;
    logic [TIME_W:0]           gap;
    logic                      gap_ok;
    logic [QW-1:0]             dvd_next;
    logic [CNT_W:0]            rem_next;
    logic [PITCH_W-1:0]        avg;
    logic signed [CMP_W-1:0]   avg_x;
    logic signed [CMP_W-1:0]   prev_x;
    logic signed [CMP_W-1:0]   db_x;
    logic [MOTION_W-1:0]       motion_next;
    logic                      step;
    logic                      out_free;

    assign accept   = sample_valid && sample_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign full     = (fill_reg == CNT_W'(WINDOW));
    assign ring_wr  = (state_reg == S_UPD);
    assign out_free = !res_valid_reg || result_ready;

    assign sample_ready = (state_reg == S_IDLE);
    assign pready       = 1'b1;

    always_comb
    begin
        case (paddr[2])
            REG_MIN_INTERVAL: prdata = APB_DW'(min_int_reg);
            REG_DEADBAND:     prdata = APB_DW'(deadband_reg);
            default:          prdata = '0;
        endcase
    end

    // drop the oldest sample once the window is full, add the new one
    always_comb
    begin
        pos_next  = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
        fill_next = full ? fill_reg : fill_reg + 1'b1;
        sum_next  = sum_reg
                  + {{(SUM_W-PITCH_W){sample_reg[PITCH_W-1]}}, sample_reg}
                  - (full ? {{(SUM_W-PITCH_W){ring_rd_reg[PITCH_W-1]}}, ring_rd_reg}
                          : SUM_W'(0));
        mag       = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
        gap       = {1'b0, time_reg} - {1'b0, last_reg};
        gap_ok    = !gap[TIME_W] && (gap[TIME_W-1:0] > TIME_W'(min_int_reg));
    end

    // two restoring-division steps per cycle
    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        for (int i = 0; i < 2; i++)
        begin
            rem_next = {rem_next[CNT_W-1:0], dvd_next[QW-1]};
            dvd_next = {dvd_next[QW-2:0], 1'b0};
            if (rem_next >= {1'b0, dsr_reg})
            begin
                rem_next    = rem_next - {1'b0, dsr_reg};
                dvd_next[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        avg    = neg_reg ? PITCH_W'(-dvd_reg[PITCH_W-1:0]) : dvd_reg[PITCH_W-1:0];
        avg_x  = {{2{avg[PITCH_W-1]}}, avg};
        prev_x = {{2{prev_reg[PITCH_W-1]}}, prev_reg};
        db_x   = CMP_W'(deadband_reg);
        motion_next = motion_reg;
        if (avg_x > prev_x + db_x)
        begin
            motion_next = MOTION_RISING;
        end
        else if (avg_x < prev_x - db_x)
        begin
            motion_next = MOTION_FALLING;
        end
        step = (motion_next != motion_reg) && (motion_next != MOTION_UNKNOWN) && gap_ok_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ring_wr)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
        if (accept)
        begin
            ring_rd_reg <= ring_mem[pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            min_int_reg    <= MIN_INT_RST;
            deadband_reg   <= DEADBAND_RST;
            pos_reg        <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            prev_reg       <= '0;
            motion_reg     <= MOTION_UNKNOWN;
            last_reg       <= '0;
            total_reg      <= '0;
            sample_reg     <= '0;
            time_reg       <= '0;
            gap_ok_reg     <= 1'b0;
            neg_reg        <= 1'b0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            dsr_reg        <= '0;
            dcnt_reg       <= '0;
            step_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_step_reg   <= 1'b0;
            res_count_reg  <= '0;
            res_avg_reg    <= '0;
            res_motion_reg <= MOTION_UNKNOWN;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[2])
                    REG_MIN_INTERVAL: min_int_reg  <= pwdata[MIN_INT_W-1:0];
                    REG_DEADBAND:     deadband_reg <= pwdata[DEADBAND_W-1:0];
                    default:          ;
                endcase
            end

            if (res_valid_reg && result_ready && (state_reg != S_OUT))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sample_reg <= pitch_sample;
                        time_reg   <= time_ms;
                        state_reg  <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    pos_reg    <= pos_next;
                    fill_reg   <= fill_next;
                    sum_reg    <= sum_next;
                    neg_reg    <= sum_next[SUM_W-1];
                    dvd_reg    <= QW'(mag);
                    rem_reg    <= '0;
                    dsr_reg    <= fill_next;
                    dcnt_reg   <= DSC_W'(DIV_STEPS);
                    gap_ok_reg <= gap_ok;
                    state_reg  <= S_DIV;
                end
                S_DIV:
                begin
                    dvd_reg  <= dvd_next;
                    rem_reg  <= rem_next;
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DSC_W'(1))
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    prev_reg   <= avg;
                    motion_reg <= motion_next;
                    step_reg   <= step;
                    if (step)
                    begin
                        last_reg <= time_reg;
                        if (total_reg != '1)
                        begin
                            total_reg <= total_reg + 1'b1;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_step_reg   <= step_reg;
                        res_count_reg  <= total_reg;
                        res_avg_reg    <= prev_reg;
                        res_motion_reg <= motion_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid   = res_valid_reg;
    assign step_detected  = res_step_reg;
    assign step_count     = res_count_reg;
    assign smoothed_pitch = res_avg_reg;
    assign motion         = res_motion_reg;

`include "swing_step_detector_core_assert.svh"

    `SSD_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CNT_W'(WINDOW), "fill count beyond window")
    `SSD_ASSERT_IMP(a_step_motion, result_valid && step_detected,
                    motion != MOTION_UNKNOWN, "step reported without known motion")
    `SSD_ASSERT_NXT(a_count_hold, state_reg != S_DEC, $stable(total_reg),
                    "step total changed outside decision cycle")
    `SSD_ASSERT_NXT(a_div_zero, state_reg == S_UPD, dsr_reg != '0, "divider loaded with zero")

endmodule

`default_nettype wire

// ===== tb/sv/swing_step_detector_core_tb.sv =====
`default_nettype none

module swing_step_detector_core_tb;

    import ssd_pkg::*;

    localparam int WINDOW      = WINDOW_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_WAIT = 40;

    typedef struct {
        logic signed [PITCH_W-1:0] pitch;
        logic [TIME_W-1:0]         stamp;
        bit                        settle;
    } swing_sample_t;

    typedef struct {
        logic                      step_hit;
        logic [COUNT_W-1:0]        steps;
        logic signed [PITCH_W-1:0] avg;
        logic [MOTION_W-1:0]       motion;
    } step_outcome_t;

    typedef enum int {READY_STEADY, READY_COIN, READY_SPARSE} ready_mode_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      sample_valid;
    logic                      sample_ready;
    logic signed [PITCH_W-1:0] pitch_sample;
    logic [TIME_W-1:0]         time_ms;
    logic                      result_valid;
    logic                      result_ready;
    logic                      step_detected;
    logic [COUNT_W-1:0]        step_count;
    logic signed [PITCH_W-1:0] smoothed_pitch;
    logic [MOTION_W-1:0]       motion;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    swing_step_detector_core #(.WINDOW(WINDOW)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .pitch_sample   (pitch_sample),
        .time_ms        (time_ms),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .step_detected  (step_detected),
        .step_count     (step_count),
        .smoothed_pitch (smoothed_pitch),
        .motion         (motion),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 clk = ~clk;

    // step tracker mirror
    logic [MIN_INT_W-1:0]  min_gap_ms = MIN_INT_RST;
    logic [DEADBAND_W-1:0] dead_zone  = DEADBAND_RST;
    int                    window_ring [WINDOW];
    int                    window_slot = 0;
    int                    window_fill = 0;
    int                    window_sum  = 0;
    int                    last_avg    = 0;
    logic [MOTION_W-1:0]   motion_now  = MOTION_UNKNOWN;
    logic [TIME_W-1:0]     last_step_ms = '0;
    logic [COUNT_W-1:0]    steps_total  = '0;

    swing_sample_t  queued_samples [$];
    step_outcome_t  predicted_steps [$];
    step_outcome_t  oldest_step;
    swing_sample_t  next_sample;

    logic [TIME_W-1:0] stamp_ms = '0;
    bit          sample_taken = 1'b0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          ready_left   = 0;
    ready_mode_t ready_mode   = READY_STEADY;
    int          mismatches   = 0;
    int          requests_sent = 0;
    int          results_seen  = 0;
    int          steps_seen    = 0;
    int          settings_used = 1;
    int          idle_cycles   = 0;

    function automatic step_outcome_t predict_step(input logic signed [PITCH_W-1:0] pitch,
                                                   input logic [TIME_W-1:0] now);
        step_outcome_t       res;
        int                  avg;
        longint              gap;
        logic [MOTION_W-1:0] was;
        res.step_hit = 1'b0;
        if (window_fill >= WINDOW)
            window_sum -= window_ring[window_slot];
        else
            window_fill++;
        window_ring[window_slot] = int'(pitch);
        window_sum += int'(pitch);
        window_slot = (window_slot + 1) % WINDOW;
        avg = window_sum / window_fill;
        was = motion_now;
        if (avg > last_avg + int'(dead_zone))
            motion_now = MOTION_RISING;
        else if (avg < last_avg - int'(dead_zone))
            motion_now = MOTION_FALLING;
        gap = longint'({24'd0, now}) - longint'({24'd0, last_step_ms});
        if (was != motion_now && motion_now != MOTION_UNKNOWN &&
            gap > longint'({48'd0, min_gap_ms}))
        begin
            res.step_hit = 1'b1;
            if (steps_total != '1)
                steps_total++;
            last_step_ms = now;
        end
        last_avg   = avg;
        res.steps  = steps_total;
        res.avg    = avg[PITCH_W-1:0];
        res.motion = motion_now;
        return res;
    endfunction

    function automatic void flag_mismatch(input string field, input longint want,
                                          input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at result %0d: expected %0d, got %0d",
                     field, results_seen, want, got);
    endfunction

    // drive requests
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            pitch_sample <= '0;
            time_ms      <= '0;
        end
        else if (!sample_valid || sample_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                sample_valid <= 1'b0;
            end
            else if (queued_samples.size() == 0 ||
                     (queued_samples[0].settle && predicted_steps.size() != 0))
                sample_valid <= 1'b0;
            else
            begin
                next_sample = queued_samples.pop_front();
                pitch_sample <= next_sample.pitch;
                time_ms      <= next_sample.stamp;
                sample_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left--;
            end
        end
    end

    // stall results
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (ready_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(2));
                ready_left = $urandom_range(10, 80);
            end
            ready_left--;
            case (ready_mode)
                READY_STEADY: result_ready <= 1'b1;
                READY_COIN:   result_ready <= 1'($urandom_range(1));
                default:      result_ready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    // predict on acceptance, check on delivery
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            sample_taken <= sample_valid && sample_ready;
            if (sample_valid && sample_ready)
            begin
                predicted_steps.push_back(predict_step(pitch_sample, time_ms));
                requests_sent++;
            end
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (step_detected === 1'b1)
                    steps_seen++;
                if (predicted_steps.size() == 0)
                    flag_mismatch("unrequested result", 0, 1);
                else
                begin
                    oldest_step = predicted_steps.pop_front();
                    if (step_detected !== oldest_step.step_hit)
                        flag_mismatch("step_detected", longint'(oldest_step.step_hit),
                                      longint'(step_detected));
                    if (step_count !== oldest_step.steps)
                        flag_mismatch("step_count", longint'(oldest_step.steps),
                                      longint'(step_count));
                    if (smoothed_pitch !== oldest_step.avg)
                        flag_mismatch("smoothed_pitch", longint'(oldest_step.avg),
                                      longint'(smoothed_pitch));
                    if (motion !== oldest_step.motion)
                        flag_mismatch("motion", longint'(oldest_step.motion),
                                      longint'(motion));
                end
            end
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no progress for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, predicted_steps.size());
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_sample(input int pitch, input logic [TIME_W-1:0] stamp);
        swing_sample_t s;
        s.pitch  = PITCH_W'(pitch);
        s.stamp  = stamp;
        s.settle = 1'b0;
        queued_samples.push_back(s);
    endtask

    // triangle swings with noise, odd samples and clock jumps
    task automatic queue_swing(input int count, input int max_dt);
        swing_sample_t s;
        int amp, half, centre, noise, k, level, r;
        amp    = 0;
        half   = 1;
        centre = 0;
        noise  = 0;
        k      = 0;
        for (int i = 0; i < count; i++)
        begin
            if (k == 0)
            begin
                amp    = $urandom_range(200, 30000);
                half   = $urandom_range(3, 25);
                centre = int'($urandom_range(0, 20000)) - 10000;
                noise  = $urandom_range(0, 2000);
            end
            level = (k < half) ? -amp + 2 * amp * k / half
                               : amp - 2 * amp * (k - half) / half;
            k = (k + 1) % (2 * half);
            r = $urandom_range(99);
            if (r < 6)
                s.pitch = PITCH_W'($urandom);
            else
                s.pitch = PITCH_W'(centre + level + int'($urandom_range(0, 2 * noise))
                                   - noise);
            r = $urandom_range(99);
            if (r < 2)
                stamp_ms = {8'($urandom), 32'($urandom)};
            else if (r < 4)
                stamp_ms = stamp_ms - $urandom_range(1, 2000);
            else
                stamp_ms = stamp_ms + $urandom_range(0, max_dt);
            s.stamp  = stamp_ms;
            s.settle = (i == count / 2) || ($urandom_range(199) == 0);
            queued_samples.push_back(s);
        end
    endtask

    task automatic await_drain();
        do
            @(posedge clk);
        while (queued_samples.size() != 0 || sample_valid || predicted_steps.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (index == REG_MIN_INTERVAL)
        begin
            min_gap_ms = value[MIN_INT_W-1:0];
            want       = APB_DW'(min_gap_ms);
        end
        else
        begin
            dead_zone = value[DEADBAND_W-1:0];
            want      = APB_DW'(dead_zone);
        end
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            flag_mismatch("register readback", longint'(want), longint'(prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input int interval, input int band);
        write_register(REG_MIN_INTERVAL, APB_DW'(interval));
        write_register(REG_DEADBAND, APB_DW'(band));
        settings_used++;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // window filling, first motion, extremes, interval edge, clock wrap and rewind
        queue_sample(0, 0);
        queue_sample(46080, 400);
        queue_sample(46080, 500);
        queue_sample(-46080, 900);
        queue_sample(-65536, 950);
        queue_sample(65535, 1200);
        queue_sample(-46080, 1201);
        queue_sample(-46080, 1600);
        queue_sample(46080, 2000);
        queue_sample(46080, 2300);
        queue_sample(-1, 2400);
        queue_sample(1, 2400);
        queue_sample(-46080, 2800);
        queue_sample(-46080, 40'hFF_FFFF_FFFF);
        queue_sample(46080, 40'hFF_FFFF_FFFF);
        queue_sample(46080, 1000);
        queue_sample(-46080, 5);
        queue_sample(-46080, 40'hAA_AAAA_AAAA);
        queue_sample(46080, 40'h55_5555_5555);
        queue_sample(46080, 40'h55_5555_5600);
        stamp_ms = 40'h55_5555_5600;
        await_drain();

        queue_swing(180, 120);
        await_drain();

        apply_setting(0, 0);
        queue_swing(180, 60);
        await_drain();

        apply_setting(65535, 2560);
        queue_swing(150, 20000);
        await_drain();

        apply_setting(120, 1000);
        queue_swing(180, 100);
        await_drain();

        apply_setting($urandom_range(0, 1000), $urandom_range(0, 400));
        queue_swing(200, 150);
        await_drain();

        if (predicted_steps.size() != 0)
            flag_mismatch("missing results", 0, longint'(predicted_steps.size()));
        $display("%0d requests over %0d register settings, %0d results checked, %0d steps",
                 requests_sent, settings_used, results_seen, steps_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
